### rtl/core/byte_stuffed_frame_builder_core_assert.svh
// Assertion helpers shared by the frame builder modules.
`ifndef BYTE_STUFFED_FRAME_BUILDER_CORE_ASSERT_SVH
`define BYTE_STUFFED_FRAME_BUILDER_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define BSFB_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bsfb assertion failed");

// Consequent checked in the cycle after the antecedent.
`define BSFB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bsfb assertion failed");

`endif

### rtl/core/bsfb_pkg.sv
package bsfb_pkg;

  // Line codes
  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_FLAG  = 8'h5E;
  localparam logic [7:0] ESC_ESC   = 8'h5D;

  // Sequencer position within one input item
  typedef enum logic [2:0] {
    PH_OPEN,
    PH_SRC,
    PH_DST,
    PH_MODE,
    PH_DATA,
    PH_CLOSE
  } phase_e;

  // One line byte on its way to the output register
  typedef struct packed {
    logic [7:0] line_byte;
    logic       frame_end;
    logic       run_last;
  } res_t;

endpackage

### rtl/core/bsfb_if.sv
// Input item channel
interface bsfb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic [7:0] dest_address;
  logic [7:0] link_mode;
  logic       last_byte;

  modport source (output valid, payload_byte, dest_address, link_mode, last_byte,
                  input ready);
  modport sink   (input valid, payload_byte, dest_address, link_mode, last_byte,
                  output ready);
endinterface

// Line byte channel
interface bsfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;
  logic       frame_end;
  logic       run_last;

  modport source (output valid, line_byte, frame_end, run_last, input ready);
  modport sink   (input valid, line_byte, frame_end, run_last, output ready);
endinterface

// Register write channel (source address)
interface bsfb_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### rtl/core/bsfb_seq.sv
`include "byte_stuffed_frame_builder_core_assert.svh"

module bsfb_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  bsfb_in_if.sink           in_i,
  input  logic [7:0]        source_address_i,
  input  logic              out_free_i,
  output logic              emit_o,
  output bsfb_pkg::res_t    res_o
);

  // Held input item
  logic       hold_q, hold_d;
  logic [7:0] pay_q, dst_q, mode_q;
  logic       last_q;

  // Sequencer state
  bsfb_pkg::phase_e phase_q, phase_d, phase_next;
  logic             esc_q, esc_d;
  logic             frame_q, frame_d;

  logic [7:0] raw_byte;
  logic [7:0] line_byte;
  logic       stuffable;
  logic       step_done;
  logic       phase_last;
  logic       finish;
  logic       accept;

  // Byte addressed by the current phase
  always_comb begin
    unique case (phase_q)
      bsfb_pkg::PH_OPEN:  raw_byte = bsfb_pkg::FLAG_BYTE;
      bsfb_pkg::PH_SRC:   raw_byte = source_address_i;
      bsfb_pkg::PH_DST:   raw_byte = dst_q;
      bsfb_pkg::PH_MODE:  raw_byte = mode_q;
      bsfb_pkg::PH_DATA:  raw_byte = pay_q;
      bsfb_pkg::PH_CLOSE: raw_byte = bsfb_pkg::FLAG_BYTE;
      default:            raw_byte = bsfb_pkg::FLAG_BYTE;
    endcase
  end

  // Stuffing: escape byte first, substitute code as the next emitted byte
  always_comb begin
    stuffable = (phase_q != bsfb_pkg::PH_OPEN) && (phase_q != bsfb_pkg::PH_CLOSE);
    priority if (esc_q) begin
      line_byte = (raw_byte == bsfb_pkg::FLAG_BYTE) ? bsfb_pkg::ESC_FLAG
                                                    : bsfb_pkg::ESC_ESC;
      step_done = 1'b1;
    end else if (stuffable && ((raw_byte == bsfb_pkg::FLAG_BYTE) ||
                               (raw_byte == bsfb_pkg::ESC_BYTE))) begin
      line_byte = bsfb_pkg::ESC_BYTE;
      step_done = 1'b0;
    end else begin
      line_byte = raw_byte;
      step_done = 1'b1;
    end
  end

  // Next phase in the fixed order of a frame
  always_comb begin
    unique case (phase_q)
      bsfb_pkg::PH_OPEN:  phase_next = bsfb_pkg::PH_SRC;
      bsfb_pkg::PH_SRC:   phase_next = bsfb_pkg::PH_DST;
      bsfb_pkg::PH_DST:   phase_next = bsfb_pkg::PH_MODE;
      bsfb_pkg::PH_MODE:  phase_next = bsfb_pkg::PH_DATA;
      bsfb_pkg::PH_DATA:  phase_next = bsfb_pkg::PH_CLOSE;
      bsfb_pkg::PH_CLOSE: phase_next = bsfb_pkg::PH_CLOSE;
      default:            phase_next = bsfb_pkg::PH_CLOSE;
    endcase
  end

  // Handshake and item completion
  always_comb begin
    phase_last = (phase_q == bsfb_pkg::PH_CLOSE) ||
                 ((phase_q == bsfb_pkg::PH_DATA) && !last_q);
    emit_o     = hold_q && out_free_i;
    finish     = emit_o && step_done && phase_last;
    in_i.ready = !hold_q || finish;
    accept     = in_i.valid && in_i.ready;
  end

  // Frame state and sequencer next values
  always_comb begin
    frame_d = finish ? (phase_q == bsfb_pkg::PH_DATA) : frame_q;
    hold_d  = accept ? 1'b1 : (finish ? 1'b0 : hold_q);
    phase_d = phase_q;
    esc_d   = esc_q;
    if (accept) begin
      phase_d = frame_d ? bsfb_pkg::PH_DATA : bsfb_pkg::PH_OPEN;
      esc_d   = 1'b0;
    end else if (emit_o) begin
      if (step_done) begin
        esc_d = 1'b0;
        if (!phase_last) begin
          phase_d = phase_next;
        end
      end else begin
        esc_d = 1'b1;
      end
    end
  end

  // Result toward the output register
  always_comb begin
    res_o.line_byte = line_byte;
    res_o.frame_end = (phase_q == bsfb_pkg::PH_CLOSE);
    res_o.run_last  = step_done && phase_last;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q  <= 1'b0;
      phase_q <= bsfb_pkg::PH_OPEN;
      esc_q   <= 1'b0;
      frame_q <= 1'b0;
    end else begin
      hold_q  <= hold_d;
      phase_q <= phase_d;
      esc_q   <= esc_d;
      frame_q <= frame_d;
    end
  end

  // Item payload, captured on each input transfer
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pay_q  <= in_i.payload_byte;
      dst_q  <= in_i.dest_address;
      mode_q <= in_i.link_mode;
      last_q <= in_i.last_byte;
    end
  end

  // An escape is pending only on header or payload bytes
  `BSFB_ASSERT_NOW(a_esc_phase, clk_i, rst_ni, esc_q, stuffable)
  // An item that opens a frame only starts when no frame is open
  `BSFB_ASSERT_NOW(a_open_closed, clk_i, rst_ni, hold_q && (phase_q == bsfb_pkg::PH_OPEN), !frame_q)
  // Closing flag always ends its item
  `BSFB_ASSERT_NOW(a_close_last, clk_i, rst_ni, emit_o && res_o.frame_end, res_o.run_last)
  // Finishing on the closing flag leaves the frame closed
  `BSFB_ASSERT_NEXT(a_close_frame, clk_i, rst_ni, finish && res_o.frame_end, !frame_q)

endmodule

### rtl/core/bsfb_out_reg.sv
`include "byte_stuffed_frame_builder_core_assert.svh"

module bsfb_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           emit_i,
  input  bsfb_pkg::res_t res_i,
  output logic           out_free_o,
  bsfb_out_if.source     out_o
);

  logic           valid_q, valid_d;
  bsfb_pkg::res_t res_q;

  // Register is free when empty or drained this cycle
  always_comb begin
    out_free_o = !valid_q || out_o.ready;
    valid_d    = emit_i ? 1'b1 : (out_o.ready ? 1'b0 : valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid     = valid_q;
  assign out_o.line_byte = res_q.line_byte;
  assign out_o.frame_end = res_q.frame_end;
  assign out_o.run_last  = res_q.run_last;

  // A new byte never overwrites one still waiting for transfer
  `BSFB_ASSERT_NOW(a_no_overwrite, clk_i, rst_ni, emit_i, !valid_q || out_o.ready)

endmodule

### rtl/core/byte_stuffed_frame_builder_core.sv
// Byte-stuffed frame builder: each accepted payload byte yields one or more line
// bytes on out_o, one per cycle while out_o is ready, through a single output
// register. A plain payload byte inside an open frame yields one line byte, a
// 0x7E or 0x7D payload byte two (escape plus code). The first byte of a frame
// adds the opening flag and the three header bytes (source, destination, mode),
// each header byte one or two line bytes, so 4 to 7 extra line bytes; a byte
// marked last adds the closing flag. Back-pressure on out_o holds the sequencer.
// The source address register is written on cfg_i, which is always ready, and
// should only change while no payload byte is in flight; it is read when a frame
// opens.
module byte_stuffed_frame_builder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  bsfb_cfg_if.sink   cfg_i,
  bsfb_in_if.sink    in_i,
  bsfb_out_if.source out_o
);

  logic [7:0]     src_addr_q;
  logic           emit;
  logic           out_free;
  bsfb_pkg::res_t res;

  // Source address register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_addr_q <= 8'h00;
    end else if (cfg_i.valid) begin
      src_addr_q <= cfg_i.data;
    end
  end

  // Framing and stuffing sequencer
  bsfb_seq u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_i             (in_i),
    .source_address_i (src_addr_q),
    .out_free_i       (out_free),
    .emit_o           (emit),
    .res_o            (res)
  );

  // Output register
  bsfb_out_reg u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .emit_i     (emit),
    .res_i      (res),
    .out_free_o (out_free),
    .out_o      (out_o)
  );

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  // One payload byte offered on the input channel
  typedef struct {
    logic [7:0] payload;
    logic [7:0] dest;
    logic [7:0] mode;
    logic       last;
    bit         hold;   // wait for all line bytes before offering this one
  } payload_item_t;

  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT   = 400000;

  logic clk_i;
  logic rst_ni;

  bsfb_cfg_if cfg_bus ();
  bsfb_in_if  in_bus ();
  bsfb_out_if out_bus ();

  byte_stuffed_frame_builder_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // Prediction state: shadow of the source address and the open-frame flag
  logic [7:0]     src_addr_shadow;
  bit             frame_open;
  bsfb_pkg::res_t line_exp_q[$];
  payload_item_t  payload_q[$];

  // Driver and monitor state
  payload_item_t tx_item;
  bit            tx_busy;
  int            tx_wait;
  int            rx_wait;
  bit            no_idle;

  int n_errors;
  int n_items;
  int n_line_bytes;
  int n_frames;
  int n_cfg_writes;
  int n_cycles;

  // Clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic int draw_gap();
    if (no_idle || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 11);
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return bsfb_pkg::ESC_BYTE;
      1: return bsfb_pkg::FLAG_BYTE;
      2: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    if (n_errors < 40) $display("[%0t] mismatch: %s", $realtime, msg);
    n_errors++;
  endtask

  // Expected line bytes
  function automatic void push_line(input logic [7:0] b, input logic fend);
    bsfb_pkg::res_t r;
    r.line_byte = b;
    r.frame_end = fend;
    r.run_last  = 1'b0;
    line_exp_q.push_back(r);
  endfunction

  function automatic void push_stuffed(input logic [7:0] b);
    if (b == bsfb_pkg::FLAG_BYTE) begin
      push_line(bsfb_pkg::ESC_BYTE, 1'b0);
      push_line(bsfb_pkg::ESC_FLAG, 1'b0);
    end else if (b == bsfb_pkg::ESC_BYTE) begin
      push_line(bsfb_pkg::ESC_BYTE, 1'b0);
      push_line(bsfb_pkg::ESC_ESC, 1'b0);
    end else begin
      push_line(b, 1'b0);
    end
  endfunction

  // Line bytes caused by one accepted payload byte
  function automatic void predict_line_bytes(input payload_item_t it);
    if (!frame_open) begin
      push_line(bsfb_pkg::FLAG_BYTE, 1'b0);
      push_stuffed(src_addr_shadow);
      push_stuffed(it.dest);
      push_stuffed(it.mode);
      frame_open = 1'b1;
    end
    push_stuffed(it.payload);
    if (it.last) begin
      push_line(bsfb_pkg::FLAG_BYTE, 1'b1);
      frame_open = 1'b0;
    end
    line_exp_q[line_exp_q.size() - 1].run_last = 1'b1;
  endfunction

  // Input driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      tx_busy = 1'b0;
      tx_wait = draw_gap();
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        predict_line_bytes(tx_item);
        n_items++;
        tx_busy = 1'b0;
        tx_wait = draw_gap();
      end
      if (!tx_busy) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (payload_q.size() > 0 &&
                     !(payload_q[0].hold && line_exp_q.size() > 0)) begin
          tx_item = payload_q.pop_front();
          tx_busy = 1'b1;
        end
      end
      in_bus.valid        <= tx_busy;
      in_bus.payload_byte <= tx_item.payload;
      in_bus.dest_address <= tx_item.dest;
      in_bus.link_mode    <= tx_item.mode;
      in_bus.last_byte    <= tx_item.last;
    end
  end

  // Output monitor with random back-pressure
  always @(posedge clk_i) begin
    bsfb_pkg::res_t exp_r;
    if (!rst_ni) begin
      rx_wait = draw_gap();
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        n_line_bytes++;
        if (out_bus.frame_end === 1'b1) n_frames++;
        if (line_exp_q.size() == 0) begin
          report_mismatch($sformatf("unexpected line byte %h", out_bus.line_byte));
        end else begin
          exp_r = line_exp_q.pop_front();
          if (out_bus.line_byte !== exp_r.line_byte ||
              out_bus.frame_end !== exp_r.frame_end ||
              out_bus.run_last !== exp_r.run_last)
            report_mismatch($sformatf("byte %h end %b last %b, want %h %b %b",
                                      out_bus.line_byte, out_bus.frame_end,
                                      out_bus.run_last, exp_r.line_byte,
                                      exp_r.frame_end, exp_r.run_last));
        end
        rx_wait = draw_gap();
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_bus.ready <= (rx_wait == 0);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d line bytes outstanding",
               n_cycles, line_exp_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic queue_byte(input logic [7:0] p, input logic [7:0] d,
                            input logic [7:0] m, input logic l, input bit h = 1'b0);
    payload_item_t it;
    it.payload = p;
    it.dest    = d;
    it.mode    = m;
    it.last    = l;
    it.hold    = h;
    payload_q.push_back(it);
  endtask

  // Block until every queued byte is sent and every line byte seen
  task automatic wait_drained();
    while (payload_q.size() > 0 || tx_busy || line_exp_q.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_source_addr(input logic [7:0] v);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= v;
    do @(posedge clk_i); while (cfg_bus.ready !== 1'b1);
    cfg_bus.valid <= 1'b0;
    src_addr_shadow = v;
    n_cfg_writes++;
  endtask

  // Mostly well-formed frames of random content, some random last flags
  task automatic queue_random_bytes(input int count);
    int done;
    int len;
    done = 0;
    while (done < count) begin
      if ($urandom_range(0, 9) < 8) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
          queue_byte(pick_byte(), pick_byte(), pick_byte(), i == len - 1,
                     $urandom_range(0, 49) == 0);
        done += len;
      end else begin
        queue_byte(pick_byte(), pick_byte(), pick_byte(), 1'($urandom_range(0, 1)));
        done++;
      end
    end
  endtask

  // Stimulus
  initial begin
    logic [7:0] src_vals[6];
    src_vals = '{8'hFF, 8'h00, 8'h7E, 8'h00, 8'h7D, 8'h00};
    src_vals[3] = 8'($urandom_range(0, 255));
    src_vals[5] = 8'($urandom_range(0, 255));
    src_addr_shadow = '0;
    frame_open      = 1'b0;
    no_idle         = 1'b0;
    tx_busy         = 1'b0;
    n_errors        = 0;
    n_items         = 0;
    n_line_bytes    = 0;
    n_frames        = 0;
    n_cfg_writes    = 0;
    n_cycles        = 0;
    rst_ni               = 1'b0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.data         = '0;
    in_bus.valid         = 1'b0;
    in_bus.payload_byte  = '0;
    in_bus.dest_address  = '0;
    in_bus.link_mode     = '0;
    in_bus.last_byte     = 1'b0;
    out_bus.ready        = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset source address: field extremes, escapes, header ignored mid-frame
    queue_byte(8'h00, 8'h00, 8'h00, 1'b1);
    queue_byte(8'hFF, 8'hFF, 8'hFF, 1'b1);
    queue_byte(bsfb_pkg::FLAG_BYTE, bsfb_pkg::ESC_BYTE, bsfb_pkg::FLAG_BYTE, 1'b0);
    queue_byte(bsfb_pkg::ESC_BYTE, 8'hAA, 8'h55, 1'b0);
    queue_byte(bsfb_pkg::FLAG_BYTE, bsfb_pkg::ESC_BYTE, bsfb_pkg::FLAG_BYTE, 1'b0);
    queue_byte(bsfb_pkg::ESC_FLAG, bsfb_pkg::ESC_ESC, bsfb_pkg::FLAG_BYTE, 1'b1);
    queue_byte(8'h12, 8'h34, 8'h56, 1'b1, 1'b1);
    wait_drained();

    // Escaped source address: single-byte frames with the most line bytes
    write_source_addr(bsfb_pkg::FLAG_BYTE);
    queue_byte(bsfb_pkg::ESC_BYTE, bsfb_pkg::FLAG_BYTE, bsfb_pkg::ESC_BYTE, 1'b1);
    queue_byte(bsfb_pkg::FLAG_BYTE, bsfb_pkg::ESC_BYTE, bsfb_pkg::FLAG_BYTE, 1'b1);
    queue_byte(8'hFF, 8'h00, 8'hFF, 1'b0);
    wait_drained();

    // Address change while a frame is still open
    write_source_addr(bsfb_pkg::ESC_BYTE);
    queue_byte(8'h00, bsfb_pkg::FLAG_BYTE, bsfb_pkg::ESC_BYTE, 1'b1);
    queue_byte(bsfb_pkg::ESC_BYTE, bsfb_pkg::FLAG_BYTE, bsfb_pkg::FLAG_BYTE, 1'b0);
    queue_byte(8'h01, 8'h80, 8'h7F, 1'b1);
    queue_byte(8'h80, 8'h01, 8'hFE, 1'b1, 1'b1);
    wait_drained();

    // Random phases, each under a new source address
    for (int ph = 0; ph < 6; ph++) begin
      write_source_addr(src_vals[ph]);
      no_idle = (ph == 1 || ph == 4);
      queue_random_bytes(70);
      wait_drained();
    end

    $display("%0d payload bytes, %0d line bytes, %0d closed frames checked",
             n_items, n_line_bytes, n_frames);
    $display("%0d source address writes incl. 00/FF and both escape codes",
             n_cfg_writes);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/bsfb_pkg.sv
rtl/core/bsfb_if.sv
rtl/core/bsfb_seq.sv
rtl/core/bsfb_out_reg.sv
rtl/core/byte_stuffed_frame_builder_core.sv
dv/tb_top.sv
